// ===== design/vertical_blend_deinterlacer_unit_defines.svh =====
// Assertion macros for the vertical blend deinterlacer.
`ifndef VERTICAL_BLEND_DEINTERLACER_UNIT_DEFINES_SVH
`define VERTICAL_BLEND_DEINTERLACER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define VBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true outside reset.
`define VBD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define VBD_ASSERT(lbl, prop, msg)
`define VBD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/vbd_pkg.sv =====
// Shared constants for the vertical blend deinterlacer.
package vbd_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int DEF_MAX_ROW_BYTES = 4096;
  localparam int DEF_MAX_ROWS      = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] ROW_BYTES_RST = 13'd1;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 13'd2;

endpackage

// ===== design/vertical_blend_deinterlacer_unit.sv =====
// Vertical [1 2 1] blend deinterlacer: line store, filter and output buffer.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o | pixel_in_i
//   out     | output    | out_valid_o/out_stall_i | pixel_out_o, last_in_run_o, frame_end_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One request per cycle while the output does not stall; the two results of a
// last-row request leave through the single output port while the next request waits.
// A request passes the line store read, then the filter into the output register.
// Reset clears counters, the pipeline and the output buffer; the line store is not
// cleared (no clearing pass); an entry read before it has been written reaches no result.
// A stall on the output holds the filter stage and then stalls the input.
`include "vertical_blend_deinterlacer_unit_defines.svh"

module vertical_blend_deinterlacer_unit
  import vbd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int MAX_ROWS      = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input request
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic                 last_in_run_o,
  output logic                 frame_end_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // compare widths: hold the clamped register and index+1
  localparam int BW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int MW = 2 * PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] row_bytes_q, row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
      row_count_q <= ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_BYTES: row_bytes_q <= cfg_data_i;
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes
  logic [BW-1:0] rb_eff;
  logic [HW-1:0] rc_eff;

  always_comb begin
    if (row_bytes_q == '0) begin
      rb_eff = BW'(1);
    end else if (BW'(row_bytes_q) > BW'(MAX_ROW_BYTES)) begin
      rb_eff = BW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = BW'(row_bytes_q);
    end
    if (HW'(row_count_q) < HW'(2)) begin
      rc_eff = HW'(2);
    end else if (HW'(row_count_q) > HW'(MAX_ROWS)) begin
      rc_eff = HW'(MAX_ROWS);
    end else begin
      rc_eff = HW'(row_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Position counters, advanced on each accepted request
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          in_take;
  logic          last_col, last_row;

  assign last_col = (BW'(col_q) + BW'(1)) >= rb_eff;
  assign last_row = (HW'(row_q) + HW'(1)) >= rc_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_take) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one word per column, {row k-2, row k-1}
  // Read on accept, written back when the filter stage moves on.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] line_mem [MAX_ROW_BYTES];
  logic [MW-1:0] rd_data_q;
  logic [MW-1:0] wr_data;
  logic          mem_we;

  // filter stage
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_row0_q, s1_row1_q, s1_lrow_q, s1_lcol_q;
  logic             s1_adv;

  // bypass when the next read hits the entry being written in the same cycle
  logic             fwd_hit_q;
  logic [MW-1:0]    fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_col_q] <= wr_data;
    end
    if (in_take) begin
      rd_data_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_take) begin
      fwd_hit_q <= mem_we && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fwd_data_q <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Filter stage
  // ---------------------------------------------------------------------------
  logic [1:0]       out_cnt_q;
  logic             out_take;

  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_take    = out_valid_o & ~out_stall_i;
  assign s1_adv      = (out_cnt_q == 2'd0) | ((out_cnt_q == 2'd1) & out_take);
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign mem_we      = s1_valid_q & s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pix_q  <= pixel_in_i;
      s1_col_q  <= col_q;
      s1_row0_q <= (row_q == '0);
      s1_row1_q <= (row_q == RW'(1));
      s1_lrow_q <= last_row;
      s1_lcol_q <= last_col;
    end
  end

  logic [MW-1:0]    word;
  logic [PIX_W-1:0] above, mid;
  logic [PIX_W+1:0] sum4;
  logic [PIX_W:0]   sum2;
  logic [PIX_W-1:0] blend4, blend2, prev_pix;

  assign word    = fwd_hit_q ? fwd_data_q : rd_data_q;
  assign above   = word[MW-1:PIX_W];
  assign mid     = word[PIX_W-1:0];
  assign wr_data = {mid, s1_pix_q};

  assign sum4   = {2'b00, above} + {1'b0, mid, 1'b0} + {2'b00, s1_pix_q} + (PIX_W+2)'(2);
  assign sum2   = {1'b0, mid} + {1'b0, s1_pix_q} + (PIX_W+1)'(1);
  assign blend4 = sum4[PIX_W+1:2];
  assign blend2 = sum2[PIX_W:1];
  // second row blends with the first only
  assign prev_pix = s1_row1_q ? blend2 : blend4;

  // ---------------------------------------------------------------------------
  // Output buffer: two slots, slot 0 is presented
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] out_pix_q  [2];
  logic             out_last_q [2];
  logic             out_fend_q [2];
  logic             s1_load;

  assign s1_load = mem_we & ~s1_row0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (s1_load) begin
      out_cnt_q <= s1_lrow_q ? 2'd2 : 2'd1;
    end else if (out_take) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      out_pix_q[0]  <= prev_pix;
      out_last_q[0] <= ~s1_lrow_q;
      out_fend_q[0] <= 1'b0;
      // last row: the row itself follows, averaged with the one above
      out_pix_q[1]  <= blend2;
      out_last_q[1] <= 1'b1;
      out_fend_q[1] <= s1_lcol_q;
    end else if (out_take && out_cnt_q == 2'd2) begin
      out_pix_q[0]  <= out_pix_q[1];
      out_last_q[0] <= out_last_q[1];
      out_fend_q[0] <= out_fend_q[1];
    end
  end

  assign pixel_out_o   = out_pix_q[0];
  assign last_in_run_o = out_last_q[0];
  assign frame_end_o   = out_fend_q[0];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `VBD_ASSERT_NEVER(a_pair_first_not_last, out_cnt_q == 2'd2 && out_last_q[0], "pair head marked last")
  `VBD_ASSERT(a_pair_tail, (out_take && out_cnt_q == 2'd2) |=> (out_valid_o && last_in_run_o), "pair tail lost")
  `VBD_ASSERT(a_fend_is_last, (out_valid_o && frame_end_o) |-> last_in_run_o, "frame end not last of run")

endmodule
